>>> hw/rtl/sha256_pkg.sv
// Shared types and constants for the SHA-256 byte-stream hasher.
// Holds the round constants, initial hash values, state codes and the
// controller-to-datapath command bundle. No dependencies.
package sha256_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ROUNDS   = 64;
    localparam int unsigned HASH_N   = 8;
    localparam int unsigned WIN_N    = 16;

    localparam logic [WORD_W-1:0] K_ROUND [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [WORD_W-1:0] H_INIT [HASH_N] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Controller states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_COMP  = 7'b0000010,
        ST_ADD   = 7'b0000100,
        ST_PAD80 = 7'b0001000,
        ST_PADZ  = 7'b0010000,
        ST_LEN   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    // Source of the byte shifted into the schedule window
    typedef enum logic [1:0] {
        SEL_DATA = 2'd0,
        SEL_PAD  = 2'd1,
        SEL_ZERO = 2'd2,
        SEL_LEN  = 2'd3
    } t_byte_sel;

    typedef struct packed {
        logic       shift_en;
        t_byte_sel  byte_sel;
        logic       bits_add;
        logic       bits_shift;
        logic       work_load;
        logic       round_en;
        logic [5:0] round_idx;
        logic       hash_add;
        logic       hash_init;
        logic [2:0] word_idx;
    } t_dp_cmd;

endpackage

>>> hw/rtl/sha256_if.sv
// Handshake channels of the SHA-256 hasher: message bytes in, digest words out.
// Depends on nothing.
interface sha256_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, message_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, message_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> hw/rtl/sha256_byte_stream_hasher_core.sv
// Top level of the SHA-256 byte-stream hasher: controller plus datapath.
// Uses sha256_pkg, sha256_if, sha256_ctrl and sha256_dp.
//
// Message bytes arrive one beat at a time; a beat may carry no byte, and a
// beat with end_of_message set closes the message. While a block fills, one
// beat is taken per cycle. The 64th byte of a block starts a compression on
// the single round unit: 64 rounds at one per cycle, then an add into the
// chaining words, and no beat is taken meanwhile. Closing a message writes
// the padding and the 64-bit length through the same byte path, one byte per
// cycle up to the end of the block with an idle step before the eight length
// bytes (plus one more block of 64 bytes when fewer than 9 bytes remain),
// with a compression after each block. The digest then leaves as eight
// 32-bit beats, word 0 first, and the hasher returns to the initial hash
// values for the next message.
module sha256_byte_stream_hasher_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sha256_byte_if.sink          i_in,
    sha256_word_if.source        o_out
);

    sha256_pkg::t_dp_cmd w_cmd;
    logic                w_out_valid;
    logic                w_last_word;
    logic [31:0]         w_digest_word;
    logic                w_in_ready;

    sha256_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in.valid),
        .i_byte_present   (i_in.byte_present),
        .i_end_of_message (i_in.end_of_message),
        .o_in_ready       (w_in_ready),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (w_out_valid),
        .o_last_word      (w_last_word),
        .o_cmd            (w_cmd)
    );

    sha256_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_message_byte (i_in.message_byte),
        .o_digest_word  (w_digest_word)
    );

    // Drive the channels
    assign i_in.ready        = w_in_ready;
    assign o_out.valid       = w_out_valid;
    assign o_out.digest_word = w_digest_word;
    assign o_out.word_index  = w_cmd.word_idx;
    assign o_out.last_word   = w_last_word;

endmodule

>>> hw/rtl/sha256_dp.sv
// Datapath of the SHA-256 hasher: schedule window, round unit, chaining words
// and bit counter. Driven by sha256_ctrl commands; uses sha256_pkg.
module sha256_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha256_pkg::t_dp_cmd  i_cmd,
    input  logic [7:0]           i_message_byte,
    output logic [31:0]          o_digest_word
);

    logic [31:0] r_w    [sha256_pkg::WIN_N];
    logic [31:0] r_v    [sha256_pkg::HASH_N];
    logic [31:0] r_hash [sha256_pkg::HASH_N];
    logic [63:0] r_bits;

    logic [7:0]  w_byte;
    logic [31:0] w_new;
    logic [31:0] w_t1;
    logic [31:0] w_t2;

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    // Pick the byte to shift in
    always_comb begin
        case (i_cmd.byte_sel)
            sha256_pkg::SEL_DATA: w_byte = i_message_byte;
            sha256_pkg::SEL_PAD:  w_byte = sha256_pkg::PAD_BYTE;
            sha256_pkg::SEL_ZERO: w_byte = 8'h00;
            sha256_pkg::SEL_LEN:  w_byte = r_bits[63:56];
            default:              w_byte = 8'h00;
        endcase
    end

    // Next schedule word and round sums
    always_comb begin
        w_new = (ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10)) + r_w[9]
              + (ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3)) + r_w[0];
        w_t1  = r_v[7] + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25))
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + sha256_pkg::K_ROUND[i_cmd.round_idx] + r_w[0];
        w_t2  = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Shift a byte into the window, or advance it one word per round
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_en) begin
            for (int i = 0; i < sha256_pkg::WIN_N - 1; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[sha256_pkg::WIN_N-1] <= {r_w[sha256_pkg::WIN_N-1][23:0], w_byte};
        end else if (i_cmd.round_en) begin
            for (int i = 0; i < sha256_pkg::WIN_N - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[sha256_pkg::WIN_N-1] <= w_new;
        end
    end

    // Working variables: load from chaining words, then one round per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.work_load) begin
            for (int i = 0; i < sha256_pkg::HASH_N; i++) begin
                r_v[i] <= r_hash[i];
            end
        end else if (i_cmd.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    // Chaining words and message bit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.hash_init) begin
            for (int i = 0; i < sha256_pkg::HASH_N; i++) begin
                r_hash[i] <= sha256_pkg::H_INIT[i];
            end
            r_bits <= 64'd0;
        end else begin
            if (i_cmd.hash_add) begin
                for (int i = 0; i < sha256_pkg::HASH_N; i++) begin
                    r_hash[i] <= r_hash[i] + r_v[i];
                end
            end
            if (i_cmd.bits_add) begin
                r_bits <= r_bits + 64'd8;
            end else if (i_cmd.bits_shift) begin
                r_bits <= {r_bits[55:0], 8'h00};
            end
        end
    end

    assign o_digest_word = r_hash[i_cmd.word_idx];

endmodule

>>> hw/rtl/sha256_ctrl.sv
// Controller of the SHA-256 hasher: byte intake, padding sequence, round
// count and digest output. Commands sha256_dp; uses sha256_pkg.
module sha256_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_byte_present,
    input  logic                 i_end_of_message,
    output logic                 o_in_ready,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_last_word,
    output sha256_pkg::t_dp_cmd  o_cmd
);

    localparam logic [5:0] CNT_LAST = 6'd63;
    localparam logic [5:0] CNT_LEN  = 6'd56;
    localparam logic [5:0] RND_LAST = 6'd63;
    localparam logic [2:0] IDX_LAST = 3'd7;

    sha256_pkg::t_state r_state, n_state;
    sha256_pkg::t_state r_ret, n_ret;
    logic [5:0] r_cnt, n_cnt;
    logic [5:0] r_round, n_round;
    logic [2:0] r_widx, n_widx;

    // Next-state and command decode
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_cnt   = r_cnt;
        n_round = r_round;
        n_widx  = r_widx;
        o_cmd   = '0;
        o_cmd.round_idx = r_round;
        o_cmd.word_idx  = r_widx;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            sha256_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_byte_present) begin
                        o_cmd.shift_en = 1'b1;
                        o_cmd.byte_sel = sha256_pkg::SEL_DATA;
                        o_cmd.bits_add = 1'b1;
                        n_cnt = r_cnt + 6'd1;
                        if (r_cnt == CNT_LAST) begin
                            o_cmd.work_load = 1'b1;
                            n_round = '0;
                            n_state = sha256_pkg::ST_COMP;
                            n_ret   = i_end_of_message ? sha256_pkg::ST_PAD80
                                                       : sha256_pkg::ST_IDLE;
                        end else if (i_end_of_message) begin
                            n_state = sha256_pkg::ST_PAD80;
                        end
                    end else if (i_end_of_message) begin
                        n_state = sha256_pkg::ST_PAD80;
                    end
                end
            end
            sha256_pkg::ST_COMP: begin
                o_cmd.round_en = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == RND_LAST) begin
                    n_state = sha256_pkg::ST_ADD;
                end
            end
            sha256_pkg::ST_ADD: begin
                o_cmd.hash_add = 1'b1;
                n_widx  = '0;
                n_state = r_ret;
            end
            sha256_pkg::ST_PAD80: begin
                o_cmd.shift_en = 1'b1;
                o_cmd.byte_sel = sha256_pkg::SEL_PAD;
                n_cnt   = r_cnt + 6'd1;
                n_state = sha256_pkg::ST_PADZ;
                if (r_cnt == CNT_LAST) begin
                    o_cmd.work_load = 1'b1;
                    n_round = '0;
                    n_state = sha256_pkg::ST_COMP;
                    n_ret   = sha256_pkg::ST_PADZ;
                end
            end
            sha256_pkg::ST_PADZ: begin
                if (r_cnt == CNT_LEN) begin
                    n_state = sha256_pkg::ST_LEN;
                end else begin
                    o_cmd.shift_en = 1'b1;
                    o_cmd.byte_sel = sha256_pkg::SEL_ZERO;
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == CNT_LAST) begin
                        o_cmd.work_load = 1'b1;
                        n_round = '0;
                        n_state = sha256_pkg::ST_COMP;
                        n_ret   = sha256_pkg::ST_PADZ;
                    end
                end
            end
            sha256_pkg::ST_LEN: begin
                o_cmd.shift_en   = 1'b1;
                o_cmd.byte_sel   = sha256_pkg::SEL_LEN;
                o_cmd.bits_shift = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == CNT_LAST) begin
                    o_cmd.work_load = 1'b1;
                    n_round = '0;
                    n_state = sha256_pkg::ST_COMP;
                    n_ret   = sha256_pkg::ST_OUT;
                end
            end
            sha256_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_widx == IDX_LAST) begin
                        o_cmd.hash_init = 1'b1;
                        n_cnt   = '0;
                        n_state = sha256_pkg::ST_IDLE;
                    end else begin
                        n_widx = r_widx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = sha256_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_last_word = (r_widx == IDX_LAST);

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha256_pkg::ST_IDLE;
            r_ret   <= sha256_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_round <= '0;
            r_widx  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_round <= n_round;
            r_widx  <= n_widx;
        end
    end

`ifndef ASSERT_OFF
    a_comp_starts_at_round0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.work_load |=> (r_state == sha256_pkg::ST_COMP && r_round == 6'd0))
        else $error("compression did not start at round zero");

    a_len_in_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha256_pkg::ST_LEN) |-> (r_cnt >= CNT_LEN))
        else $error("length bytes placed before byte 56");

    a_out_starts_at_word0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha256_pkg::ST_OUT && $past(r_state) == sha256_pkg::ST_ADD)
            |-> (r_widx == 3'd0))
        else $error("digest output did not start at word zero");

    a_digest_ends_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.hash_init |=> (r_state == sha256_pkg::ST_IDLE && r_cnt == 6'd0))
        else $error("hasher not idle after last digest word");
`endif

endmodule
